/* design/eab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eab_pkg
// Types, register map, observer constants and the micro-program of the
// balance controller step.
// ----------------------------------------------------------------------------
package eab_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_HALF
  } op_t;

  typedef enum logic [4:0] {
    R_ZERO,
    R_KPW,
    R_KVW,
    R_KPC,
    R_KVC,
    R_BW,
    R_BC,
    R_DT,
    R_L1,
    R_L2,
    R_L3,
    R_YW,
    R_YC,
    R_WPOS,
    R_WVEL,
    R_WDIS,
    R_CPOS,
    R_CVEL,
    R_CDIS,
    R_T0,
    R_T1,
    R_UW,
    R_UC,
    R_TOT,
    R_ERR,
    R_D0,
    R_D1,
    R_D2
  } opnd_t;

  typedef struct packed {
    op_t   op;
    opnd_t src_a;
    opnd_t src_b;
    opnd_t dst;
  } uop_t;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PROG_LAST = 6'd41;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_W     = 25;

  localparam logic [2:0] REG_WHEEL_POS_GAIN   = 3'd0;
  localparam logic [2:0] REG_WHEEL_VEL_GAIN   = 3'd1;
  localparam logic [2:0] REG_COM_POS_GAIN     = 3'd2;
  localparam logic [2:0] REG_COM_VEL_GAIN     = 3'd3;
  localparam logic [2:0] REG_WHEEL_INPUT_GAIN = 3'd4;
  localparam logic [2:0] REG_COM_INPUT_GAIN   = 3'd5;
  localparam logic [2:0] REG_STEP_TIME        = 3'd6;

  localparam longint RST_WHEEL_POS_GAIN   = -64'sd232471816;
  localparam longint RST_WHEEL_VEL_GAIN   = -64'sd495904306;
  localparam longint RST_COM_POS_GAIN     = -64'sd15997313693;
  localparam longint RST_COM_VEL_GAIN     = -64'sd5552065636;
  localparam longint RST_WHEEL_INPUT_GAIN = 64'sd4838339;
  localparam longint RST_COM_INPUT_GAIN   = -64'sd1440185;
  localparam logic [STEP_W-1:0] RST_STEP_TIME = 25'd16777;

  // Observer gains in Q.32.
  localparam longint L1_Q32 = 64'sd4982162063346;
  localparam longint L2_Q32 = 64'sd744912240442859;
  localparam longint L3_Q32 = 64'sd5771746310514335;

  function automatic longint clip_to_width(input longint v, input int w);
    longint hi;
    longint lo;
    hi = longint'(64'h7FFF_FFFF_FFFF_FFFF >> (64 - w));
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic longint q32_to_frac(input longint q, input int frac, input int w);
    longint m;
    longint hi;
    int     s;
    s = 32 - frac;
    m = q;
    if (s > 0) begin
      m = (q + (64'sd1 <<< (s - 1))) >>> s;
    end
    hi = longint'(64'h7FFF_FFFF_FFFF_FFFF >> (64 - w));
    if (m > hi) begin
      m = hi;
    end
    return m;
  endfunction

  function automatic uop_t fetch_uop(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    case (pc)
      6'd0:  u = '{OP_MUL,  R_KPW,  R_WPOS, R_T0};
      6'd1:  u = '{OP_SUB,  R_ZERO, R_T0,   R_T0};
      6'd2:  u = '{OP_MUL,  R_KVW,  R_WVEL, R_T1};
      6'd3:  u = '{OP_SUB,  R_T0,   R_T1,   R_UW};
      6'd4:  u = '{OP_MUL,  R_KPC,  R_CPOS, R_T0};
      6'd5:  u = '{OP_SUB,  R_ZERO, R_T0,   R_T0};
      6'd6:  u = '{OP_MUL,  R_KVC,  R_CVEL, R_T1};
      6'd7:  u = '{OP_SUB,  R_T0,   R_T1,   R_UC};
      6'd8:  u = '{OP_ADD,  R_UW,   R_UC,   R_TOT};
      6'd9:  u = '{OP_DIV,  R_WDIS, R_BW,   R_T0};
      6'd10: u = '{OP_SUB,  R_TOT,  R_T0,   R_TOT};
      6'd11: u = '{OP_DIV,  R_CDIS, R_BC,   R_T0};
      6'd12: u = '{OP_SUB,  R_TOT,  R_T0,   R_TOT};
      6'd13: u = '{OP_HALF, R_TOT,  R_ZERO, R_TOT};
      6'd14: u = '{OP_SUB,  R_YW,   R_WPOS, R_ERR};
      6'd15: u = '{OP_MUL,  R_L1,   R_ERR,  R_T0};
      6'd16: u = '{OP_ADD,  R_WVEL, R_T0,   R_D0};
      6'd17: u = '{OP_MUL,  R_L2,   R_ERR,  R_T0};
      6'd18: u = '{OP_ADD,  R_WDIS, R_T0,   R_T0};
      6'd19: u = '{OP_MUL,  R_BW,   R_UW,   R_T1};
      6'd20: u = '{OP_ADD,  R_T0,   R_T1,   R_D1};
      6'd21: u = '{OP_MUL,  R_L3,   R_ERR,  R_D2};
      6'd22: u = '{OP_MUL,  R_D0,   R_DT,   R_T0};
      6'd23: u = '{OP_ADD,  R_WPOS, R_T0,   R_WPOS};
      6'd24: u = '{OP_MUL,  R_D1,   R_DT,   R_T0};
      6'd25: u = '{OP_ADD,  R_WVEL, R_T0,   R_WVEL};
      6'd26: u = '{OP_MUL,  R_D2,   R_DT,   R_T0};
      6'd27: u = '{OP_ADD,  R_WDIS, R_T0,   R_WDIS};
      6'd28: u = '{OP_SUB,  R_YC,   R_CPOS, R_ERR};
      6'd29: u = '{OP_MUL,  R_L1,   R_ERR,  R_T0};
      6'd30: u = '{OP_ADD,  R_CVEL, R_T0,   R_D0};
      6'd31: u = '{OP_MUL,  R_L2,   R_ERR,  R_T0};
      6'd32: u = '{OP_ADD,  R_CDIS, R_T0,   R_T0};
      6'd33: u = '{OP_MUL,  R_BC,   R_UC,   R_T1};
      6'd34: u = '{OP_ADD,  R_T0,   R_T1,   R_D1};
      6'd35: u = '{OP_MUL,  R_L3,   R_ERR,  R_D2};
      6'd36: u = '{OP_MUL,  R_D0,   R_DT,   R_T0};
      6'd37: u = '{OP_ADD,  R_CPOS, R_T0,   R_CPOS};
      6'd38: u = '{OP_MUL,  R_D1,   R_DT,   R_T0};
      6'd39: u = '{OP_ADD,  R_CVEL, R_T0,   R_CVEL};
      6'd40: u = '{OP_MUL,  R_D2,   R_DT,   R_T0};
      6'd41: u = '{OP_ADD,  R_CDIS, R_T0,   R_CDIS};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* design/eso_adrc_balance_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eso_adrc_balance_step
// Balance controller tick: state feedback with disturbance rejection, then
// one Euler step of two third-order extended state observers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in_       slave      tvalid/tready        wheel_angle, com_angle
// out_      master     tvalid/tready        wheel_torque, com_angle_est; tuser flags
// cfg_      APB slave  psel/penable/pready  seven registers at 8-byte strides
//
// A micro-program of 42 operations runs on one saturating adder, one 32x32
// multiplier used over NCH*NCH partial products, and a one-bit-per-cycle
// divider. The divider dominates the run time of a beat.
// in_tready is high only while idle. A finished result waits in the output
// register, so a new beat is accepted while it is stalled downstream.
// Reset is synchronous, clears the estimates and loads the register defaults.
// ----------------------------------------------------------------------------
module eso_adrc_balance_step
  import eab_pkg::*;
#(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // wheel_angle, com_angle
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // wheel_torque, com_angle_est
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     out_tdata,
  // saturated, gain_fault
  output logic [1:0]                            out_tuser,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                 cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                 cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                 cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int TD_W   = ((2*DATA_WIDTH+7)/8)*8;
  localparam int CH     = 32;
  localparam int NCH    = (W + CH - 1) / CH;
  localparam int MW     = NCH * CH;
  localparam int NPP    = NCH * NCH;
  localparam int IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DIVN   = W + F;
  localparam int CNT_W  = $clog2(DIVN + 1);
  localparam int ACC_W  = (2*MW > W + 2*F) ? 2*MW : W + 2*F;
  localparam int SH_W   = ACC_W - F;

  localparam logic [W-1:0] RST_KPW = W'(clip_to_width(RST_WHEEL_POS_GAIN, W));
  localparam logic [W-1:0] RST_KVW = W'(clip_to_width(RST_WHEEL_VEL_GAIN, W));
  localparam logic [W-1:0] RST_KPC = W'(clip_to_width(RST_COM_POS_GAIN, W));
  localparam logic [W-1:0] RST_KVC = W'(clip_to_width(RST_COM_VEL_GAIN, W));
  localparam logic [W-1:0] RST_BW  = W'(clip_to_width(RST_WHEEL_INPUT_GAIN, W));
  localparam logic [W-1:0] RST_BC  = W'(clip_to_width(RST_COM_INPUT_GAIN, W));
  localparam logic [W-1:0] LC1     = W'(q32_to_frac(L1_Q32, F, W));
  localparam logic [W-1:0] LC2     = W'(q32_to_frac(L2_Q32, F, W));
  localparam logic [W-1:0] LC3     = W'(q32_to_frac(L3_Q32, F, W));
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  state_t state_r, state_nxt;

  logic [W-1:0]       kpw_r, kvw_r, kpc_r, kvc_r, bw_r, bc_r;
  logic [STEP_W-1:0]  dt_r;

  logic [W-1:0] yw_r, yw_nxt, yc_r, yc_nxt;
  logic [W-1:0] wpos_r, wpos_nxt, wvel_r, wvel_nxt, wdis_r, wdis_nxt;
  logic [W-1:0] cpos_r, cpos_nxt, cvel_r, cvel_nxt, cdis_r, cdis_nxt;
  logic [W-1:0] t0_r, t0_nxt, t1_r, t1_nxt, uw_r, uw_nxt, uc_r, uc_nxt;
  logic [W-1:0] tot_r, tot_nxt, err_r, err_nxt;
  logic [W-1:0] d0_r, d0_nxt, d1_r, d1_nxt, d2_r, d2_nxt;

  logic [PC_W-1:0]  upc_r, upc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [MW-1:0]    ma_r, ma_nxt, mb_r, mb_nxt;
  logic [IDX_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic [2*CH-1:0]  pp_r, pp_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [DIVN-1:0]  dn_r, dn_nxt;
  logic [W-1:0]     rem_r, rem_nxt, dd_r, dd_nxt;
  logic             sat_r, sat_nxt, fault_r, fault_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_torque_r, out_torque_nxt, out_com_r, out_com_nxt;
  logic             out_sat_r, out_sat_nxt, out_fault_r, out_fault_nxt;

  uop_t         uop;
  logic [W-1:0] opa, opb;
  logic [W-1:0] mag_a, mag_b;
  logic         last_op;
  logic         in_fire;
  logic         out_free;
  logic         cfg_wr;
  logic [2:0]   cfg_idx;

  logic [2*CH-1:0]  prod;
  logic [ACC_W-1:0] pp_sh;
  logic [W:0]       as_ext;
  logic             as_ovf;
  logic [W-1:0]     as_res;
  logic [W-1:0]     half_mag, half_m, half_res;
  logic [W:0]       trial;
  logic             trial_ge;
  logic [W:0]       trial_diff;
  logic             div_rnd;
  logic [SH_W-1:0]  wb_sh, wb_lim;
  logic             wb_sat;
  logic [W-1:0]     wb_mag, wb_res;
  logic             wr_en;
  logic [W-1:0]     wr_data;

  function automatic logic [W-1:0] opnd_val(input opnd_t s);
    logic [W-1:0] v;
    case (s)
      R_ZERO:  v = '0;
      R_KPW:   v = kpw_r;
      R_KVW:   v = kvw_r;
      R_KPC:   v = kpc_r;
      R_KVC:   v = kvc_r;
      R_BW:    v = bw_r;
      R_BC:    v = bc_r;
      R_DT:    v = W'(dt_r);
      R_L1:    v = LC1;
      R_L2:    v = LC2;
      R_L3:    v = LC3;
      R_YW:    v = yw_r;
      R_YC:    v = yc_r;
      R_WPOS:  v = wpos_r;
      R_WVEL:  v = wvel_r;
      R_WDIS:  v = wdis_r;
      R_CPOS:  v = cpos_r;
      R_CVEL:  v = cvel_r;
      R_CDIS:  v = cdis_r;
      R_T0:    v = t0_r;
      R_T1:    v = t1_r;
      R_UW:    v = uw_r;
      R_UC:    v = uc_r;
      R_TOT:   v = tot_r;
      R_ERR:   v = err_r;
      R_D0:    v = d0_r;
      R_D1:    v = d1_r;
      R_D2:    v = d2_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop      = fetch_uop(upc_r);

  always_comb begin
    opa = opnd_val(uop.src_a);
    opb = opnd_val(uop.src_b);
  end

  assign mag_a    = opa[W-1] ? (~opa + 1'b1) : opa;
  assign mag_b    = opb[W-1] ? (~opb + 1'b1) : opb;
  assign last_op  = (upc_r == PROG_LAST);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];

  always_comb begin
    case (cfg_idx)
      REG_WHEEL_POS_GAIN:   cfg_prdata = CFG_DATA_W'(kpw_r);
      REG_WHEEL_VEL_GAIN:   cfg_prdata = CFG_DATA_W'(kvw_r);
      REG_COM_POS_GAIN:     cfg_prdata = CFG_DATA_W'(kpc_r);
      REG_COM_VEL_GAIN:     cfg_prdata = CFG_DATA_W'(kvc_r);
      REG_WHEEL_INPUT_GAIN: cfg_prdata = CFG_DATA_W'(bw_r);
      REG_COM_INPUT_GAIN:   cfg_prdata = CFG_DATA_W'(bc_r);
      REG_STEP_TIME:        cfg_prdata = CFG_DATA_W'(dt_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Shared arithmetic.
  assign prod  = (2*CH)'(ma_r[ia_r*CH +: CH]) * (2*CH)'(mb_r[ib_r*CH +: CH]);
  assign pp_sh = ACC_W'(pp_r) << ((32'(pa_r) + 32'(pb_r)) * CH);

  assign as_ext = (uop.op == OP_SUB) ? ({opa[W-1], opa} - {opb[W-1], opb})
                                     : ({opa[W-1], opa} + {opb[W-1], opb});
  assign as_ovf = as_ext[W] != as_ext[W-1];
  assign as_res = as_ovf ? (as_ext[W] ? MIN_VAL : MAX_VAL) : as_ext[W-1:0];

  assign half_mag = mag_a;
  assign half_m   = W'(({1'b0, half_mag} + 1'b1) >> 1);
  assign half_res = opa[W-1] ? (~half_m + 1'b1) : half_m;

  assign trial      = {rem_r, dn_r[DIVN-1]};
  assign trial_ge   = trial >= {1'b0, dd_r};
  assign trial_diff = trial - {1'b0, dd_r};
  assign div_rnd    = {rem_r, 1'b0} >= {1'b0, dd_r};

  assign wb_sh  = acc_r[ACC_W-1:F];
  assign wb_lim = neg_r ? SH_W'(MIN_VAL) : SH_W'(MAX_VAL);
  assign wb_sat = wb_sh > wb_lim;
  assign wb_mag = wb_sat ? wb_lim[W-1:0] : wb_sh[W-1:0];
  assign wb_res = neg_r ? (~wb_mag + 1'b1) : wb_mag;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        case (uop.op)
          OP_MUL: state_nxt = ST_MUL;
          OP_DIV: state_nxt = (opb == '0) ? ST_WB : ST_DIV;
          default: state_nxt = last_op ? ST_DONE : ST_RUN;
        endcase
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(NPP)) begin
          state_nxt = ST_WB;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIVN)) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt = last_op ? ST_DONE : ST_RUN;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    yw_nxt         = yw_r;
    yc_nxt         = yc_r;
    upc_nxt        = upc_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    pp_nxt         = pp_r;
    acc_nxt        = acc_r;
    dn_nxt         = dn_r;
    rem_nxt        = rem_r;
    dd_nxt         = dd_r;
    sat_nxt        = sat_r;
    fault_nxt      = fault_r;
    out_valid_nxt  = out_valid_r;
    out_torque_nxt = out_torque_r;
    out_com_nxt    = out_com_r;
    out_sat_nxt    = out_sat_r;
    out_fault_nxt  = out_fault_r;
    wr_en          = 1'b0;
    wr_data        = as_res;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          yw_nxt    = in_tdata[W-1:0];
          yc_nxt    = in_tdata[2*W-1:W];
          upc_nxt   = '0;
          sat_nxt   = 1'b0;
          fault_nxt = 1'b0;
        end
      end
      ST_RUN: begin
        case (uop.op)
          OP_MUL: begin
            ma_nxt  = MW'(mag_a);
            mb_nxt  = MW'(mag_b);
            neg_nxt = opa[W-1] ^ opb[W-1];
            acc_nxt = ACC_W'(1) << (F - 1);
            ia_nxt  = '0;
            ib_nxt  = '0;
            cnt_nxt = '0;
          end
          OP_DIV: begin
            neg_nxt = opa[W-1] ^ opb[W-1];
            dn_nxt  = DIVN'(mag_a) << F;
            dd_nxt  = mag_b;
            rem_nxt = '0;
            cnt_nxt = '0;
            if (opb == '0) begin
              acc_nxt   = '0;
              fault_nxt = 1'b1;
            end
          end
          OP_HALF: begin
            wr_en   = 1'b1;
            wr_data = half_res;
            upc_nxt = upc_r + 1'b1;
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = as_res;
            if (as_ovf) begin
              sat_nxt = 1'b1;
            end
            upc_nxt = upc_r + 1'b1;
          end
        endcase
      end
      ST_MUL: begin
        if (cnt_r < CNT_W'(NPP)) begin
          pp_nxt = prod;
          pa_nxt = ia_r;
          pb_nxt = ib_r;
          if (ib_r == IDX_W'(NCH - 1)) begin
            ib_nxt = '0;
            ia_nxt = (ia_r == IDX_W'(NCH - 1)) ? '0 : ia_r + 1'b1;
          end else begin
            ib_nxt = ib_r + 1'b1;
          end
        end
        if (cnt_r != '0) begin
          acc_nxt = acc_r + pp_sh;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIVN)) begin
          acc_nxt = ACC_W'({1'b0, dn_r} + (DIVN+1)'(div_rnd)) << F;
        end else begin
          rem_nxt = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
          dn_nxt  = {dn_r[DIVN-2:0], trial_ge};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WB: begin
        wr_en   = 1'b1;
        wr_data = wb_res;
        if (wb_sat) begin
          sat_nxt = 1'b1;
        end
        upc_nxt = upc_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_torque_nxt = tot_r;
          out_com_nxt    = cpos_r;
          out_sat_nxt    = sat_r;
          out_fault_nxt  = fault_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Register file write-back.
  always_comb begin
    wpos_nxt = wpos_r;
    wvel_nxt = wvel_r;
    wdis_nxt = wdis_r;
    cpos_nxt = cpos_r;
    cvel_nxt = cvel_r;
    cdis_nxt = cdis_r;
    t0_nxt   = t0_r;
    t1_nxt   = t1_r;
    uw_nxt   = uw_r;
    uc_nxt   = uc_r;
    tot_nxt  = tot_r;
    err_nxt  = err_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    if (wr_en) begin
      case (uop.dst)
        R_WPOS:  wpos_nxt = wr_data;
        R_WVEL:  wvel_nxt = wr_data;
        R_WDIS:  wdis_nxt = wr_data;
        R_CPOS:  cpos_nxt = wr_data;
        R_CVEL:  cvel_nxt = wr_data;
        R_CDIS:  cdis_nxt = wr_data;
        R_T0:    t0_nxt   = wr_data;
        R_T1:    t1_nxt   = wr_data;
        R_UW:    uw_nxt   = wr_data;
        R_UC:    uc_nxt   = wr_data;
        R_TOT:   tot_nxt  = wr_data;
        R_ERR:   err_nxt  = wr_data;
        R_D0:    d0_nxt   = wr_data;
        R_D1:    d1_nxt   = wr_data;
        R_D2:    d2_nxt   = wr_data;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'({out_com_r, out_torque_r});
  assign out_tuser  = {out_fault_r, out_sat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      upc_r       <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      fault_r     <= 1'b0;
      wpos_r      <= '0;
      wvel_r      <= '0;
      wdis_r      <= '0;
      cpos_r      <= '0;
      cvel_r      <= '0;
      cdis_r      <= '0;
      kpw_r       <= RST_KPW;
      kvw_r       <= RST_KVW;
      kpc_r       <= RST_KPC;
      kvc_r       <= RST_KVC;
      bw_r        <= RST_BW;
      bc_r        <= RST_BC;
      dt_r        <= RST_STEP_TIME;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      fault_r     <= fault_nxt;
      wpos_r      <= wpos_nxt;
      wvel_r      <= wvel_nxt;
      wdis_r      <= wdis_nxt;
      cpos_r      <= cpos_nxt;
      cvel_r      <= cvel_nxt;
      cdis_r      <= cdis_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_WHEEL_POS_GAIN:   kpw_r <= cfg_pwdata[W-1:0];
          REG_WHEEL_VEL_GAIN:   kvw_r <= cfg_pwdata[W-1:0];
          REG_COM_POS_GAIN:     kpc_r <= cfg_pwdata[W-1:0];
          REG_COM_VEL_GAIN:     kvc_r <= cfg_pwdata[W-1:0];
          REG_WHEEL_INPUT_GAIN: bw_r  <= cfg_pwdata[W-1:0];
          REG_COM_INPUT_GAIN:   bc_r  <= cfg_pwdata[W-1:0];
          REG_STEP_TIME:        dt_r  <= cfg_pwdata[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    yw_r         <= yw_nxt;
    yc_r         <= yc_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    uw_r         <= uw_nxt;
    uc_r         <= uc_nxt;
    tot_r        <= tot_nxt;
    err_r        <= err_nxt;
    d0_r         <= d0_nxt;
    d1_r         <= d1_nxt;
    d2_r         <= d2_nxt;
    neg_r        <= neg_nxt;
    ma_r         <= ma_nxt;
    mb_r         <= mb_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    pp_r         <= pp_nxt;
    acc_r        <= acc_nxt;
    dn_r         <= dn_nxt;
    rem_r        <= rem_nxt;
    dd_r         <= dd_nxt;
    out_torque_r <= out_torque_nxt;
    out_com_r    <= out_com_nxt;
    out_sat_r    <= out_sat_nxt;
    out_fault_r  <= out_fault_nxt;
  end

endmodule
`default_nettype wire
